// ===== rtl/pairwise_hamming_match_unit_assert.svh =====
// Assertion macros for the pairwise Hamming match unit.
`ifndef PAIRWISE_HAMMING_MATCH_UNIT_ASSERT_SVH
`define PAIRWISE_HAMMING_MATCH_UNIT_ASSERT_SVH

// Antecedent implies consequent in the same cycle.
`define PWHM_ASSERT_IMPLIES(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Antecedent implies consequent in the next cycle.
`define PWHM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/pwhm_pkg.sv =====
// Shared constants, types and helper functions of the pairwise Hamming match unit.
`default_nettype none
package pwhm_pkg;

  localparam int HASH_BITS  = 64;
  localparam int MAX_HASHES = 64;
  localparam int IDX_W      = $clog2(MAX_HASHES);
  localparam int CNT_W      = IDX_W + 1;
  localparam int PAIR_W     = 11;
  localparam int CODE_W     = 7;
  localparam int CFG_W      = 7;
  localparam int BYTES      = HASH_BITS / 8;
  localparam int OF_DEPTH   = 4;
  localparam int OF_AW      = $clog2(OF_DEPTH);

  // Register indexes on the configuration port
  localparam logic CFG_SET_SIZE  = 1'b0;
  localparam logic CFG_THRESHOLD = 1'b1;

  localparam logic [CFG_W-1:0] SET_SIZE_RESET  = CFG_W'(MAX_HASHES);
  localparam logic [CFG_W-1:0] THRESHOLD_RESET = '0;

  typedef struct packed {
    logic [HASH_BITS-1:0] hash;
    logic [IDX_W-1:0]     newer;
    logic [CNT_W-1:0]     size;
  } job_t;

  typedef struct packed {
    logic [IDX_W-1:0]  newer;
    logic [IDX_W-1:0]  older;
    logic [PAIR_W-1:0] pair;
    logic [CODE_W-1:0] code;
    logic              last;
  } res_t;

  // Clamp the programmed set size to 2 .. MAX_HASHES
  function automatic logic [CNT_W-1:0] sat_size(input logic [CFG_W-1:0] s);
    logic [CNT_W-1:0] r;
    r = CNT_W'(s);
    if (s < CFG_W'(2)) begin
      r = CNT_W'(2);
    end else if (s > CFG_W'(MAX_HASHES)) begin
      r = CNT_W'(MAX_HASHES);
    end
    return r;
  endfunction

  function automatic logic [3:0] pop8(input logic [7:0] b);
    logic [3:0] c;
    c = '0;
    for (int k = 0; k < 8; k++) begin
      c = c + 4'(b[k]);
    end
    return c;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/pairwise_hamming_match_unit.sv =====
// Top level of the pairwise Hamming match unit: config registers and the three parts.
//
// Usage: push 64-bit hashes on the in_ channel (valid/ready). Hash number i of a
// set (i = 0 .. n-1, n = set_size clamped to 2..64) is stored and compared with
// every earlier hash j < i of the set; each comparison gives one beat on the
// out_ channel, in order of increasing j, carrying i, j, the triangular pair
// index, the match code (distance + 1 when within threshold, else 0) and a
// last_of_run flag on j = i - 1. The first hash of a set gives no beat.
// Throughput: the compare engine reads one table entry per cycle while the
// result queue has room, so hash i occupies it for i reads plus a job load.
// The front end and a two-deep job queue take the next hashes meanwhile.
// Reset (rst_n low, synchronous) empties all queues, returns the set position
// to zero, set_size to 64 and distance_threshold to 0; the table is not cleared.
// Write cfg_ registers only while idle. When out_ready is low the result queue
// fills and the engine holds its read pointer; nothing is dropped.
`default_nettype none
`include "pairwise_hamming_match_unit_assert.svh"
module pairwise_hamming_match_unit (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire logic [pwhm_pkg::HASH_BITS-1:0] in_hash_value,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output logic [pwhm_pkg::IDX_W-1:0]          out_newer_index,
  output logic [pwhm_pkg::IDX_W-1:0]          out_older_index,
  output logic [pwhm_pkg::PAIR_W-1:0]         out_pair_index,
  output logic [pwhm_pkg::CODE_W-1:0]         out_match_code,
  output logic                                out_last_of_run,
  input  wire logic                           cfg_we,
  input  wire logic                           cfg_index,
  input  wire logic [pwhm_pkg::CFG_W-1:0]     cfg_data
);

  logic [pwhm_pkg::CFG_W-1:0] set_size_r;
  logic [pwhm_pkg::CFG_W-1:0] threshold_r;

  logic           job_push, job_full, job_pop, job_valid;
  pwhm_pkg::job_t front_job, head_job;
  pwhm_pkg::res_t res;

  // Configuration registers: no read-back, take the write at once
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      set_size_r  <= pwhm_pkg::SET_SIZE_RESET;
      threshold_r <= pwhm_pkg::THRESHOLD_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        pwhm_pkg::CFG_SET_SIZE:  set_size_r  <= cfg_data;
        pwhm_pkg::CFG_THRESHOLD: threshold_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Front end: position within the set, wrap on a shrunk size
  pwhm_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_hash_value (in_hash_value),
    .set_size      (set_size_r),
    .job_full      (job_full),
    .job_push      (job_push),
    .job           (front_job)
  );

  // Decouple accept from compare
  pwhm_job_fifo u_job_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (job_push),
    .push_job (front_job),
    .full     (job_full),
    .pop      (job_pop),
    .valid    (job_valid),
    .head     (head_job)
  );

  // Compare engine: one stored hash per cycle while the result queue has room
  pwhm_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .job_valid (job_valid),
    .job       (head_job),
    .job_pop   (job_pop),
    .threshold (threshold_r),
    .res_valid (out_valid),
    .res_ready (out_ready),
    .res       (res)
  );

  assign out_newer_index = res.newer;
  assign out_older_index = res.older;
  assign out_pair_index  = res.pair;
  assign out_match_code  = res.code;
  assign out_last_of_run = res.last;

  // Older hash always precedes the newer one
  `PWHM_ASSERT_IMPLIES(a_order, out_valid, out_older_index < out_newer_index, "older index not below newer index")
  // The last beat of a run pairs neighbouring positions
  `PWHM_ASSERT_IMPLIES(a_last_adj, out_valid && out_last_of_run, pwhm_pkg::IDX_W'(out_older_index + pwhm_pkg::IDX_W'(1)) == out_newer_index, "last beat not on adjacent pair")
  // Match code never exceeds the hash width plus one
  `PWHM_ASSERT_IMPLIES(a_code_range, out_valid, out_match_code <= pwhm_pkg::CODE_W'(pwhm_pkg::HASH_BITS + 1), "match code out of range")
  // A job that starts a run is never followed at once by another job load
  `PWHM_ASSERT_NEXT(a_job_load, job_pop && (head_job.newer != '0), !job_pop, "engine reloaded while running")

endmodule
`default_nettype wire

// ===== rtl/pwhm_front.sv =====
// Front end: accepts hashes, assigns the position in the set and issues jobs.
`default_nettype none
module pwhm_front (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic [pwhm_pkg::HASH_BITS-1:0] in_hash_value,
  input  wire logic [pwhm_pkg::CFG_W-1:0]    set_size,
  input  wire logic                          job_full,
  output logic                               job_push,
  output pwhm_pkg::job_t                     job
);

  logic [pwhm_pkg::CNT_W-1:0] count_r, count_nxt;
  logic [pwhm_pkg::CNT_W-1:0] size_eff;
  logic [pwhm_pkg::CNT_W-1:0] pos;
  logic [pwhm_pkg::CNT_W-1:0] pos_inc;

  always_comb begin
    size_eff = pwhm_pkg::sat_size(set_size);
    // a shrunk set size restarts the set
    pos      = (count_r >= size_eff) ? '0 : count_r;
    pos_inc  = pos + pwhm_pkg::CNT_W'(1);
    in_ready = !job_full;
    job_push = in_valid && in_ready;
    count_nxt = count_r;
    if (job_push) begin
      count_nxt = (pos_inc >= size_eff) ? '0 : pos_inc;
    end
    job.hash  = in_hash_value;
    job.newer = pos[pwhm_pkg::IDX_W-1:0];
    job.size  = size_eff;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/pwhm_job_fifo.sv =====
// Two-entry job queue between the front end and the compare engine.
`default_nettype none
module pwhm_job_fifo (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           push,
  input  wire pwhm_pkg::job_t push_job,
  output logic                full,
  input  wire logic           pop,
  output logic                valid,
  output pwhm_pkg::job_t      head
);

  pwhm_pkg::job_t ent_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r, cnt_nxt;

  always_comb begin
    full  = (cnt_r == 2'd2);
    valid = (cnt_r != 2'd0);
    head  = ent_r[rp_r];
    cnt_nxt = cnt_r;
    if (push && !(pop && valid)) begin
      cnt_nxt = cnt_r + 2'd1;
    end else if (!push && pop && valid) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wp_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) begin
        wp_r <= !wp_r;
      end
      if (pop && valid) begin
        rp_r <= !rp_r;
      end
    end
  end

endmodule
`default_nettype wire

// ===== rtl/pwhm_back.sv =====
// Compare engine: hash table, pipelined XOR popcount and result queue.
`default_nettype none
module pwhm_back (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       job_valid,
  input  wire pwhm_pkg::job_t             job,
  output logic                            job_pop,
  input  wire logic [pwhm_pkg::CFG_W-1:0] threshold,
  output logic                            res_valid,
  input  wire logic                       res_ready,
  output pwhm_pkg::res_t                  res
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_RUN  = 1'b1;

  logic state_r, state_nxt;

  // current job
  logic [pwhm_pkg::HASH_BITS-1:0] cur_hash_r;
  logic [pwhm_pkg::IDX_W-1:0]     cur_i_r;
  logic [pwhm_pkg::CNT_W-1:0]     cur_n_r;
  logic [pwhm_pkg::IDX_W-1:0]     j_r;
  logic [pwhm_pkg::PAIR_W-1:0]    pair_r;

  logic [pwhm_pkg::HASH_BITS-1:0] tbl_mem [pwhm_pkg::MAX_HASHES];

  // read stage
  logic                           s1_v_r;
  logic [pwhm_pkg::HASH_BITS-1:0] s1_rd_r;
  logic [pwhm_pkg::HASH_BITS-1:0] s1_hash_r;
  logic [pwhm_pkg::IDX_W-1:0]     s1_i_r, s1_j_r;
  logic [pwhm_pkg::PAIR_W-1:0]    s1_pair_r;
  logic                           s1_last_r;

  // popcount stage
  logic                           s2_v_r;
  logic [3:0]                     s2_cnt_r [pwhm_pkg::BYTES];
  logic [pwhm_pkg::IDX_W-1:0]     s2_i_r, s2_j_r;
  logic [pwhm_pkg::PAIR_W-1:0]    s2_pair_r;
  logic                           s2_last_r;

  // result queue
  pwhm_pkg::res_t                 of_r [pwhm_pkg::OF_DEPTH];
  logic [pwhm_pkg::OF_AW-1:0]     of_wp_r, of_rp_r;
  logic [pwhm_pkg::OF_AW:0]       of_cnt_r;

  logic [pwhm_pkg::HASH_BITS-1:0] diff;
  logic [pwhm_pkg::OF_AW:0]       occ;
  logic                           issue;
  logic                           issue_last;
  logic [pwhm_pkg::PAIR_W-1:0]    pair_step;
  logic [pwhm_pkg::CODE_W-1:0]    hdist;
  pwhm_pkg::res_t                 s2_res;
  logic                           of_pop;

  always_comb begin
    job_pop    = (state_r == ST_IDLE) && job_valid;
    // count results in flight so the queue never overflows
    occ        = of_cnt_r + (pwhm_pkg::OF_AW + 1)'(s1_v_r) + (pwhm_pkg::OF_AW + 1)'(s2_v_r);
    issue      = (state_r == ST_RUN) && (occ < (pwhm_pkg::OF_AW + 1)'(pwhm_pkg::OF_DEPTH));
    issue_last = (pwhm_pkg::IDX_W'(j_r + pwhm_pkg::IDX_W'(1)) == cur_i_r);
    // pair(j+1) - pair(j) = n - j - 2
    pair_step  = pwhm_pkg::PAIR_W'(cur_n_r) - pwhm_pkg::PAIR_W'(j_r) - pwhm_pkg::PAIR_W'(2);
    diff       = s1_hash_r ^ s1_rd_r;

    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (job_pop && (job.newer != '0)) begin
          state_nxt = ST_RUN;
        end
      end
      ST_RUN: begin
        if (issue && issue_last) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase

    hdist = '0;
    for (int k = 0; k < pwhm_pkg::BYTES; k++) begin
      hdist = hdist + pwhm_pkg::CODE_W'(s2_cnt_r[k]);
    end
    s2_res.newer = s2_i_r;
    s2_res.older = s2_j_r;
    s2_res.pair  = s2_pair_r;
    s2_res.code  = (hdist <= threshold) ? pwhm_pkg::CODE_W'(hdist + pwhm_pkg::CODE_W'(1)) : '0;
    s2_res.last  = s2_last_r;

    res_valid = (of_cnt_r != '0);
    res       = of_r[of_rp_r];
    of_pop    = res_valid && res_ready;
  end

  // table write on job load, table read on issue
  always_ff @(posedge clk) begin
    if (job_pop) begin
      tbl_mem[job.newer] <= job.hash;
    end
    if (issue) begin
      s1_rd_r <= tbl_mem[j_r];
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (job_pop) begin
      cur_hash_r <= job.hash;
      cur_i_r    <= job.newer;
      cur_n_r    <= job.size;
      j_r        <= '0;
      pair_r     <= pwhm_pkg::PAIR_W'(job.newer) - pwhm_pkg::PAIR_W'(1);
    end else if (issue) begin
      j_r    <= pwhm_pkg::IDX_W'(j_r + pwhm_pkg::IDX_W'(1));
      pair_r <= pwhm_pkg::PAIR_W'(pair_r + pair_step);
    end
    if (issue) begin
      s1_hash_r <= cur_hash_r;
      s1_i_r    <= cur_i_r;
      s1_j_r    <= j_r;
      s1_pair_r <= pair_r;
      s1_last_r <= issue_last;
    end
    if (s1_v_r) begin
      for (int k = 0; k < pwhm_pkg::BYTES; k++) begin
        s2_cnt_r[k] <= pwhm_pkg::pop8(diff[8*k +: 8]);
      end
      s2_i_r    <= s1_i_r;
      s2_j_r    <= s1_j_r;
      s2_pair_r <= s1_pair_r;
      s2_last_r <= s1_last_r;
    end
    if (s2_v_r) begin
      of_r[of_wp_r] <= s2_res;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      s1_v_r   <= 1'b0;
      s2_v_r   <= 1'b0;
      of_wp_r  <= '0;
      of_rp_r  <= '0;
      of_cnt_r <= '0;
    end else begin
      state_r <= state_nxt;
      s1_v_r  <= issue;
      s2_v_r  <= s1_v_r;
      if (s2_v_r) begin
        of_wp_r <= pwhm_pkg::OF_AW'(of_wp_r + pwhm_pkg::OF_AW'(1));
      end
      if (of_pop) begin
        of_rp_r <= pwhm_pkg::OF_AW'(of_rp_r + pwhm_pkg::OF_AW'(1));
      end
      if (s2_v_r && !of_pop) begin
        of_cnt_r <= of_cnt_r + (pwhm_pkg::OF_AW + 1)'(1);
      end else if (!s2_v_r && of_pop) begin
        of_cnt_r <= of_cnt_r - (pwhm_pkg::OF_AW + 1)'(1);
      end
    end
  end

endmodule
`default_nettype wire
